// ----- rtl/lef_pkg.sv -----
// Shared constants and types for the Laplacian edge filter.
package lef_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4095;

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned WidW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CntW  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CfgW  = 12;
  localparam int unsigned PixW  = 8;

  localparam logic [CfgW-1:0] RstWidth  = CfgW'(640);
  localparam logic [CfgW-1:0] RstHeight = CfgW'(480);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } lef_reg_e;

  typedef struct packed {
    logic produce;
    logic left_en;
    logic up_en;
    logic right_en;
    logic down_en;
    logic eor;
    logic eof;
  } lef_ctrl_t;

  typedef struct packed {
    logic [ColW-1:0] addr;
    logic [PixW-1:0] pix;
    lef_ctrl_t       ctrl;
  } lef_s1_t;

endpackage

// ----- rtl/laplacian_edge_filter.sv -----
// Top level: streaming 4-neighbour Laplacian edge filter with two line memories.
// Pipeline: a transaction's line memory read is registered at acceptance and its result
//   (for the pixel one row plus one pixel earlier) is registered on leaving stage 1.
// Throughput: one pixel per cycle unless stalled; set by one read-modify-write per RAM.
// Reset: registers 640 x 480, counters and window cleared; line memories are not cleared
//   and need no clearing pass, border masking hides every unwritten entry.
module laplacian_edge_filter
  import lef_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [PixW-1:0] pixel_i,
  input  logic            is_flush_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] edge_value_o,
  output logic            end_of_row_o,
  output logic            end_of_frame_o
);

  logic [CfgW-1:0] width_q, height_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CntW-1:0] items_q, items_d;

  logic            s1_valid_q;
  lef_s1_t         s1_q, s1_d;
  logic            s1_adv, in_acc;

  logic [PixW-1:0] newer_mem [MAX_WIDTH];
  logic [PixW-1:0] older_mem [MAX_WIDTH];
  logic [PixW-1:0] rd_newer_q, rd_older_q;

  logic [3*PixW-1:0] win_q;
  logic [PixW-1:0]   prev_q;

  logic            out_valid_q;
  logic [PixW-1:0] out_edge_q;
  logic            out_eor_q, out_eof_q;

  logic [WidW-1:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic [ColW-1:0] cc;
  logic [RowW-1:0] rc;
  lef_ctrl_t       ctrl;
  logic            cfg_hit;

  // effective frame size
  always_comb begin
    if (width_q == '0) begin
      w_eff = WidW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WidW'(MAX_WIDTH);
    end else begin
      w_eff = WidW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RowW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = RowW'(MAX_HEIGHT);
    end else begin
      h_eff = RowW'(height_q);
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_hit    = cfg_we_i;

  // position and border flags of the pixel whose result this transaction yields
  always_comb begin
    cc = (col_q == '0) ? ColW'(w_eff - WidW'(1)) : col_q - ColW'(1);
    rc = row_q - RowW'(1) - ((col_q == '0) ? RowW'(1) : RowW'(0));
    ctrl.produce  = items_q > CntW'(w_eff);
    ctrl.eor      = WidW'(cc) == (w_eff - WidW'(1));
    ctrl.left_en  = cc != '0;
    ctrl.up_en    = rc != '0;
    ctrl.right_en = !ctrl.eor;
    ctrl.down_en  = rc != (h_eff - RowW'(1));
    ctrl.eof      = ctrl.eor && !ctrl.down_en;

    s1_d.addr = col_q;
    s1_d.pix  = is_flush_i ? '0 : pixel_i;
    s1_d.ctrl = ctrl;

    col_d   = col_q;
    row_d   = row_q;
    items_d = items_q;
    if (ctrl.produce && ctrl.eof) begin
      col_d   = '0;
      row_d   = '0;
      items_d = '0;
    end else begin
      if (!ctrl.produce) begin
        items_d = items_q + CntW'(1);
      end
      if ((WidW'(col_q) + WidW'(1)) >= w_eff) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RstWidth;
      height_q <= RstHeight;
      col_q    <= '0;
      row_q    <= '0;
      items_q  <= '0;
    end else if (cfg_hit) begin
      case (lef_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    width_q  <= width_q;
      endcase
      col_q   <= '0;
      row_q   <= '0;
      items_q <= '0;
    end else if (in_acc) begin
      col_q   <= col_d;
      row_q   <= row_d;
      items_q <= items_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // line memories: read at acceptance, write back when the transaction leaves stage 1
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      newer_mem[s1_q.addr] <= s1_q.pix;
      older_mem[s1_q.addr] <= rd_newer_q;
    end
    if (in_acc) begin
      if (s1_adv && s1_q.addr == col_q) begin
        rd_newer_q <= s1_q.pix;
        rd_older_q <= rd_newer_q;
      end else begin
        rd_newer_q <= newer_mem[col_q];
        rd_older_q <= older_mem[col_q];
      end
    end
  end

  // window and previous pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_hit) begin
      win_q <= '0;
    end else if (s1_adv) begin
      if (s1_q.ctrl.produce && s1_q.ctrl.eof) begin
        win_q <= '0;
      end else begin
        win_q <= {rd_older_q, rd_newer_q, win_q[2*PixW-1:PixW]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      prev_q <= s1_q.pix;
    end
  end

  // Laplacian magnitude
  logic [PixW-1:0] left_v, right_v, up_v, down_v, centre_v;
  logic [PixW+1:0] sum_pos, cen4, mag;

  always_comb begin
    left_v   = s1_q.ctrl.left_en  ? win_q[PixW-1:0]        : '0;
    centre_v = win_q[2*PixW-1:PixW];
    up_v     = s1_q.ctrl.up_en    ? win_q[3*PixW-1:2*PixW] : '0;
    right_v  = s1_q.ctrl.right_en ? rd_newer_q             : '0;
    down_v   = s1_q.ctrl.down_en  ? prev_q                 : '0;
    sum_pos  = (PixW+2)'(left_v) + (PixW+2)'(right_v) + (PixW+2)'(up_v) + (PixW+2)'(down_v);
    cen4     = {centre_v, 2'b00};
    mag      = (sum_pos >= cen4) ? (sum_pos - cen4) : (cen4 - sum_pos);
  end

  // output register; |t|/4 never exceeds 255
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.ctrl.produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.ctrl.produce) begin
      out_edge_q <= mag[PixW+1:2];
      out_eor_q  <= s1_q.ctrl.eor;
      out_eof_q  <= s1_q.ctrl.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign edge_value_o   = out_edge_q;
  assign end_of_row_o   = out_eor_q;
  assign end_of_frame_o = out_eof_q;

endmodule

// ----- rtl/lef_checker.sv -----
// Port-level checker for the Laplacian edge filter and its bind.
module lef_checker
  import lef_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [PixW-1:0] edge_value_o,
  input logic            end_of_row_o,
  input logic            end_of_frame_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edge_value_o)
      && $stable(end_of_row_o) && $stable(end_of_frame_o))
    else $error("stalled result changed");

  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_row_o)
    else $error("end of frame without end of row");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled while output side free");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind laplacian_edge_filter lef_checker u_lef_checker (.*);
